// ----- rtl/frustum_box_cull_top_macros.svh -----
// ----------------------------------------------------------------------------
// frustum_box_cull_top_macros.svh
// Assertion macros for the frustum box cull block; empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_TOP_MACROS_SVH
`define FRUSTUM_BOX_CULL_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define FBC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define FBC_NEVER(lbl, clk, rstn, expr, msg) \
    `FBC_ASSERT(lbl, clk, rstn, !(expr), msg)

`else

`define FBC_ASSERT(lbl, clk, rstn, prop, msg)

`define FBC_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ----- rtl/fbc_pkg.sv -----
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared constants and types for the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int FIELD_W         = 32;
    localparam int MODE_W          = 2;
    localparam int INDEX_W         = 3;
    localparam int COUNT_W         = 4;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_PLANES_DEF  = 8;
    localparam int COORD_WIDTH_DEF = 32;

    localparam logic [COUNT_W-1:0] PLANE_COUNT_RST = COUNT_W'(6);

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_WRITE = 2'd0;
    localparam t_mode MODE_ALL   = 2'd1;
    localparam t_mode MODE_ONE   = 2'd2;
    localparam t_mode MODE_NONE  = 2'd3;

endpackage

// ----- rtl/frustum_box_cull_top.sv -----
// Results: a box result is loaded into the output register once the n planes tested
//   (1 to MAX_PLANES, or none) have left the pipeline; mode 0 and mode 3 words give no result.
// One box is in work at a time: input is ready only in idle. The single plane-RAM read
//   port feeds one plane per cycle into a three-stage multiply and add pipeline.
// Reset (synchronous, active low): plane_count to 6, all planes read as zero
//   through per-entry valid flags, no result pending; no clearing pass.
// ----------------------------------------------------------------------------
// frustum_box_cull_top
// Clip-plane table with box culling: picks the far corner per plane and checks
// the sign of n.corner + d over the stored planes.
// ----------------------------------------------------------------------------
`include "frustum_box_cull_top_macros.svh"

module frustum_box_cull_top #(
    parameter int MAX_PLANES  = fbc_pkg::MAX_PLANES_DEF,
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [fbc_pkg::COUNT_W-1:0] i_cfg_data,
    // input words
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [fbc_pkg::MODE_W-1:0]  i_mode,
    input  logic [fbc_pkg::INDEX_W-1:0] i_plane_index,
    input  logic [fbc_pkg::FIELD_W-1:0] i_normal_x,
    input  logic [fbc_pkg::FIELD_W-1:0] i_normal_y,
    input  logic [fbc_pkg::FIELD_W-1:0] i_normal_z,
    input  logic [fbc_pkg::FIELD_W-1:0] i_plane_offset,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_low_x,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_low_y,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_low_z,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_high_x,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_high_y,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_high_z,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_inside_res
);

    import fbc_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int AW    = $clog2(MAX_PLANES);
    localparam int CNT_W = $clog2(MAX_PLANES + 1);
    localparam int PW    = 2 * CW;
    localparam int SW    = PW + 2;
    localparam int RAM_W = 4 * CW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state                 r_state;
    logic [COUNT_W-1:0]     r_plane_count;
    logic [MAX_PLANES-1:0]  r_entry_vld;
    logic [CNT_W-1:0]       r_left;
    logic [AW-1:0]          r_addr;
    logic                   r_s1_v;
    logic                   r_s2_v;
    logic                   r_s3_v;
    logic                   r_fail;
    logic                   r_out_valid;
    logic                   r_out_inside;

    // payload pipeline
    logic                   r_s1_ev;
    logic signed [CW-1:0]   r_lo_x, r_lo_y, r_lo_z;
    logic signed [CW-1:0]   r_hi_x, r_hi_y, r_hi_z;
    logic signed [PW-1:0]   r_s2_px, r_s2_py, r_s2_pz, r_s2_d;
    logic signed [SW-1:0]   r_s3_a, r_s3_b;

    logic                   in_accept;
    logic                   idx_ok;
    logic [CNT_W-1:0]       all_count;
    logic                   issue;
    logic                   done;
    logic                   slot_free;
    logic                   out_load;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [RAM_W-1:0]       ram_wdata;
    logic [RAM_W-1:0]       ram_rdata;
    logic signed [CW-1:0]   nx, ny, nz, d;
    logic signed [PW-1:0]   d_ext;
    logic signed [SW-1:0]   sum;

    assign in_accept = i_in_valid && o_in_ready;
    assign idx_ok    = int'(i_plane_index) < MAX_PLANES;
    assign all_count = (int'(r_plane_count) > MAX_PLANES) ? CNT_W'(MAX_PLANES)
                                                          : CNT_W'(r_plane_count);

    assign ram_we    = in_accept && (i_mode == MODE_WRITE) && idx_ok;
    assign ram_waddr = AW'(i_plane_index);
    assign ram_wdata = {i_plane_offset[CW-1:0], i_normal_z[CW-1:0],
                        i_normal_y[CW-1:0], i_normal_x[CW-1:0]};

    // writes happen only in idle, reads only while running: no overlap to forward
    assign issue = (r_state == ST_RUN) && (r_left != '0);
    assign done  = (r_state == ST_RUN) && (r_left == '0) && !r_s1_v && !r_s2_v && !r_s3_v;
    assign slot_free = !r_out_valid || i_out_ready;
    assign out_load  = slot_free && (done || (r_state == ST_DONE));

    fbc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_PLANES)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // never-written planes read as zero
    assign nx = r_s1_ev ? $signed(ram_rdata[CW-1:0])      : '0;
    assign ny = r_s1_ev ? $signed(ram_rdata[2*CW-1:CW])   : '0;
    assign nz = r_s1_ev ? $signed(ram_rdata[3*CW-1:2*CW]) : '0;
    assign d  = r_s1_ev ? $signed(ram_rdata[4*CW-1:3*CW]) : '0;

    assign d_ext = $signed({{(PW-CW){d[CW-1]}}, d}) <<< FRAC_BITS;
    assign sum   = r_s3_a + r_s3_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_plane_count <= PLANE_COUNT_RST;
            r_entry_vld   <= '0;
            r_left        <= '0;
            r_addr        <= '0;
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_s3_v        <= 1'b0;
            r_fail        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_inside  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_plane_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_inside <= !r_fail;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (r_s3_v && sum[SW-1]) begin
                r_fail <= 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        case (i_mode)
                            MODE_WRITE: begin
                                if (idx_ok) begin
                                    r_entry_vld[ram_waddr] <= 1'b1;
                                end
                            end
                            MODE_ALL: begin
                                r_left  <= all_count;
                                r_addr  <= '0;
                                r_fail  <= 1'b0;
                                r_state <= ST_RUN;
                            end
                            MODE_ONE: begin
                                // an index beyond the table tests nothing
                                r_left  <= idx_ok ? CNT_W'(1) : '0;
                                r_addr  <= ram_waddr;
                                r_fail  <= 1'b0;
                                r_state <= ST_RUN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        r_addr <= r_addr + AW'(1);
                        r_left <= r_left - CNT_W'(1);
                    end
                    if (done) begin
                        r_state <= slot_free ? ST_IDLE : ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_lo_x <= $signed(i_corner_low_x[CW-1:0]);
            r_lo_y <= $signed(i_corner_low_y[CW-1:0]);
            r_lo_z <= $signed(i_corner_low_z[CW-1:0]);
            r_hi_x <= $signed(i_corner_high_x[CW-1:0]);
            r_hi_y <= $signed(i_corner_high_y[CW-1:0]);
            r_hi_z <= $signed(i_corner_high_z[CW-1:0]);
        end
        r_s1_ev <= r_entry_vld[r_addr];
        // far corner: high coordinate where the normal is not negative
        r_s2_px <= nx * (nx[CW-1] ? r_lo_x : r_hi_x);
        r_s2_py <= ny * (ny[CW-1] ? r_lo_y : r_hi_y);
        r_s2_pz <= nz * (nz[CW-1] ? r_lo_z : r_hi_z);
        r_s2_d  <= d_ext;
        r_s3_a  <= $signed({{2{r_s2_px[PW-1]}}, r_s2_px})
                 + $signed({{2{r_s2_py[PW-1]}}, r_s2_py});
        r_s3_b  <= $signed({{2{r_s2_pz[PW-1]}}, r_s2_pz})
                 + $signed({{2{r_s2_d[PW-1]}}, r_s2_d});
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;

    `FBC_ASSERT(a_issue_in_run, i_clk, i_rst_n, r_s1_v |-> $past(r_state == ST_RUN), "plane read outside a run")
    `FBC_NEVER(a_write_while_busy, i_clk, i_rst_n, ram_we && (r_s1_v || r_s2_v || r_s3_v), "plane write during a test")
    `FBC_ASSERT(a_result_from_job, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state != ST_IDLE), "result without a test")
    `FBC_NEVER(a_left_bound, i_clk, i_rst_n, int'(r_left) > MAX_PLANES, "plane counter beyond table")
    `FBC_ASSERT(a_left_in_run, i_clk, i_rst_n, (r_left != '0) |-> (r_state == ST_RUN), "planes pending outside a run")

endmodule

// ----- rtl/fbc_ram.sv -----
// ----------------------------------------------------------------------------
// fbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/frustum_box_cull_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_box_cull_checker
// Watches the configuration, input and result channels of the frustum box
// cull block. It keeps its own plane table and plane count, works out the
// inside/culled verdict of every accepted box and compares the result words
// in order.
// ----------------------------------------------------------------------------
module frustum_box_cull_checker #(
    parameter int MAX_PLANES = fbc_pkg::MAX_PLANES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fbc_pkg::COUNT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [fbc_pkg::MODE_W-1:0]  i_mode,
    input  logic [fbc_pkg::INDEX_W-1:0] i_plane_index,
    input  logic [fbc_pkg::FIELD_W-1:0] i_normal_x,
    input  logic [fbc_pkg::FIELD_W-1:0] i_normal_y,
    input  logic [fbc_pkg::FIELD_W-1:0] i_normal_z,
    input  logic [fbc_pkg::FIELD_W-1:0] i_plane_offset,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_low_x,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_low_y,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_low_z,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_high_x,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_high_y,
    input  logic [fbc_pkg::FIELD_W-1:0] i_corner_high_z,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_inside_res,
    output int                          o_fail_count,
    output int                          o_pending
);

    import fbc_pkg::*;

    logic signed [FIELD_W-1:0] plane_nx_tbl [MAX_PLANES];
    logic signed [FIELD_W-1:0] plane_ny_tbl [MAX_PLANES];
    logic signed [FIELD_W-1:0] plane_nz_tbl [MAX_PLANES];
    logic signed [FIELD_W-1:0] plane_d_tbl  [MAX_PLANES];
    logic signed [FIELD_W-1:0] box_lo [3];
    logic signed [FIELD_W-1:0] box_hi [3];
    logic [COUNT_W-1:0]        plane_count;
    bit                        inside_expected_q [$];
    bit                        verdict;
    bit                        want;
    int                        tested;

    // n times the corner furthest along n, exact in 72 bits
    function automatic logic signed [71:0] far_term(input logic signed [FIELD_W-1:0] n,
                                                     input logic signed [FIELD_W-1:0] lo,
                                                     input logic signed [FIELD_W-1:0] hi);
        logic signed [71:0] wide_n;
        logic signed [71:0] wide_c;
        wide_n = n;
        wide_c = (n >= 0) ? hi : lo;
        return wide_n * wide_c;
    endfunction

    function automatic bit clears_plane(input int p);
        logic signed [71:0] acc;
        logic signed [71:0] wide_d;
        wide_d = plane_d_tbl[p];
        acc = wide_d <<< FRAC_BITS;
        acc = acc + far_term(plane_nx_tbl[p], box_lo[0], box_hi[0])
                  + far_term(plane_ny_tbl[p], box_lo[1], box_hi[1])
                  + far_term(plane_nz_tbl[p], box_lo[2], box_hi[2]);
        return !acc[71];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < MAX_PLANES; p++) begin
                plane_nx_tbl[p] = '0;
                plane_ny_tbl[p] = '0;
                plane_nz_tbl[p] = '0;
                plane_d_tbl[p]  = '0;
            end
            plane_count = PLANE_COUNT_RST;
            inside_expected_q.delete();
            o_pending    = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we)
                plane_count = i_cfg_data;

            // results first, so a word accepted at this edge cannot match
            if (i_out_valid && i_out_ready) begin
                if (inside_expected_q.size() == 0) begin
                    $display("%0t: unexpected result word, inside_res %0b", $time,
                             i_inside_res);
                    o_fail_count++;
                end else begin
                    want = inside_expected_q.pop_front();
                    if (i_inside_res !== want) begin
                        $display("%0t: inside_res mismatch, expected %0b actual %0b",
                                 $time, want, i_inside_res);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                box_lo[0] = i_corner_low_x;
                box_lo[1] = i_corner_low_y;
                box_lo[2] = i_corner_low_z;
                box_hi[0] = i_corner_high_x;
                box_hi[1] = i_corner_high_y;
                box_hi[2] = i_corner_high_z;
                case (i_mode)
                    MODE_WRITE: begin
                        if (int'(i_plane_index) < MAX_PLANES) begin
                            plane_nx_tbl[i_plane_index] = i_normal_x;
                            plane_ny_tbl[i_plane_index] = i_normal_y;
                            plane_nz_tbl[i_plane_index] = i_normal_z;
                            plane_d_tbl[i_plane_index]  = i_plane_offset;
                        end
                    end
                    MODE_ALL: begin
                        verdict = 1'b1;
                        tested  = (int'(plane_count) > MAX_PLANES) ? MAX_PLANES
                                                                    : int'(plane_count);
                        for (int p = 0; p < tested; p++)
                            if (!clears_plane(p))
                                verdict = 1'b0;
                        inside_expected_q = {inside_expected_q, verdict};
                    end
                    MODE_ONE: begin
                        if (int'(i_plane_index) < MAX_PLANES)
                            verdict = clears_plane(int'(i_plane_index));
                        else
                            verdict = 1'b1;
                        inside_expected_q = {inside_expected_q, verdict};
                    end
                    default: ;  // unused mode, dropped by the block
                endcase
            end
            o_pending = inside_expected_q.size();
        end
    end

endmodule

// ----- dv/frustum_box_cull_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_box_cull_top_tb
// Drives plane writes and box tests into the frustum box cull block with
// random gaps and result back-pressure, steps the plane count through its
// range between phases, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module frustum_box_cull_top_tb;
    import fbc_pkg::*;

    localparam logic [FIELD_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [FIELD_W-1:0] V_MIN = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] V_MAX = 32'h7FFF_FFFF;
    localparam int WORDS_PER_PHASE = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 16;

    typedef struct {
        t_mode              mode;
        logic [INDEX_W-1:0] idx;
        logic [FIELD_W-1:0] nx, ny, nz, d;
        logic [FIELD_W-1:0] lo [3];
        logic [FIELD_W-1:0] hi [3];
    } t_cull_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [COUNT_W-1:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [MODE_W-1:0]  i_mode = '0;
    logic [INDEX_W-1:0] i_plane_index = '0;
    logic [FIELD_W-1:0] i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic [FIELD_W-1:0] i_plane_offset = '0;
    logic [FIELD_W-1:0] i_corner_low_x = '0, i_corner_low_y = '0, i_corner_low_z = '0;
    logic [FIELD_W-1:0] i_corner_high_x = '0, i_corner_high_y = '0, i_corner_high_z = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_inside_res;

    int fail_count;
    int pending;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    bit roomy = 1'b0;

    frustum_box_cull_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_plane_index   (i_plane_index),
        .i_normal_x      (i_normal_x),
        .i_normal_y      (i_normal_y),
        .i_normal_z      (i_normal_z),
        .i_plane_offset  (i_plane_offset),
        .i_corner_low_x  (i_corner_low_x),
        .i_corner_low_y  (i_corner_low_y),
        .i_corner_low_z  (i_corner_low_z),
        .i_corner_high_x (i_corner_high_x),
        .i_corner_high_y (i_corner_high_y),
        .i_corner_high_z (i_corner_high_z),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_inside_res    (o_inside_res)
    );

    frustum_box_cull_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_plane_index   (i_plane_index),
        .i_normal_x      (i_normal_x),
        .i_normal_y      (i_normal_y),
        .i_normal_z      (i_normal_z),
        .i_plane_offset  (i_plane_offset),
        .i_corner_low_x  (i_corner_low_x),
        .i_corner_low_y  (i_corner_low_y),
        .i_corner_low_z  (i_corner_low_z),
        .i_corner_high_x (i_corner_high_x),
        .i_corner_high_y (i_corner_high_y),
        .i_corner_high_z (i_corner_high_z),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_inside_res    (o_inside_res),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_value(input int span_log2);
        int r;
        int half;
        r = $urandom_range(0, 99);
        half = 1 << span_log2;
        if (r < 12)
            return $urandom;
        if (r < 22) begin
            case ($urandom_range(0, 4))
                0: return V_MIN;
                1: return V_MAX;
                2: return '0;
                3: return 32'hFFFF_FFFF;
                default: return Q_ONE;
            endcase
        end
        return 32'($urandom_range(0, 2 * half) - half);
    endfunction

    function automatic t_cull_word plane_word(input logic [INDEX_W-1:0] idx,
                                              input logic [FIELD_W-1:0] nx, ny, nz, d);
        t_cull_word w;
        w.mode = MODE_WRITE;
        w.idx  = idx;
        w.nx = nx; w.ny = ny; w.nz = nz; w.d = d;
        for (int k = 0; k < 3; k++) begin
            w.lo[k] = $urandom;
            w.hi[k] = $urandom;
        end
        return w;
    endfunction

    function automatic t_cull_word box_word(input t_mode mode, input logic [INDEX_W-1:0] idx,
                                            input logic [FIELD_W-1:0] lx, ly, lz,
                                            input logic [FIELD_W-1:0] hx, hy, hz);
        t_cull_word w;
        w.mode = mode;
        w.idx  = idx;
        w.nx = $urandom; w.ny = $urandom; w.nz = $urandom; w.d = $urandom;
        w.lo[0] = lx; w.lo[1] = ly; w.lo[2] = lz;
        w.hi[0] = hx; w.hi[1] = hy; w.hi[2] = hz;
        return w;
    endfunction

    function automatic t_cull_word random_word();
        t_cull_word w;
        int r;
        int shape;
        r = $urandom_range(0, 99);
        if (r < 18) begin
            w = plane_word(3'($urandom_range(0, 7)), pick_value(17), pick_value(17),
                           pick_value(17), pick_value(21));
            if (roomy && $urandom_range(0, 9) < 8)
                w.d = 32'($urandom_range(1 << 22, 1 << 24));
            return w;
        end
        w = box_word(MODE_ALL, 3'($urandom_range(0, 7)), '0, '0, '0, '0, '0, '0);
        if (r >= 55)
            w.mode = MODE_ONE;
        if (r >= 95)
            w.mode = MODE_NONE;
        shape = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) begin
            w.lo[k] = pick_value(21);
            if (shape < 75)
                w.hi[k] = w.lo[k] + 32'($urandom_range(0, 1 << 20));
            else if (shape < 87)
                w.hi[k] = w.lo[k];  // point
            else
                w.hi[k] = pick_value(21);
        end
        return w;
    endfunction

    task automatic drive_word(input t_cull_word w);
        int gap;
        i_in_valid      <= 1'b1;
        i_mode          <= w.mode;
        i_plane_index   <= w.idx;
        i_normal_x      <= w.nx;
        i_normal_y      <= w.ny;
        i_normal_z      <= w.nz;
        i_plane_offset  <= w.d;
        i_corner_low_x  <= w.lo[0];
        i_corner_low_y  <= w.lo[1];
        i_corner_low_z  <= w.lo[2];
        i_corner_high_x <= w.hi[0];
        i_corner_high_y <= w.hi[1];
        i_corner_high_z <= w.hi[2];
        do @(posedge i_clk); while (!o_in_ready);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and let every result and any write in flight finish
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_plane_count(input logic [COUNT_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] phase_counts [11];
        phase_counts = '{4'd8, 4'd15, 4'd1, 4'd6, 4'd0, 4'd9, 4'd3, 4'd7, 4'd2, 4'd5, 4'd4};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // cleared table: every plane passes
        drive_word(box_word(MODE_ALL, 3'd0, V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
        drive_word(box_word(MODE_ONE, 3'd3, '0, '0, '0, '0, '0, '0));
        // plane x >= 0
        drive_word(plane_word(3'd0, Q_ONE, '0, '0, '0));
        drive_word(box_word(MODE_ALL, 3'd0, -5 * Q_ONE, '0, '0, -Q_ONE, '0, '0));
        drive_word(box_word(MODE_ONE, 3'd0, '0, '0, '0, '0, '0, '0));  // on the plane
        drive_word(box_word(MODE_ONE, 3'd0, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, '0, '0));
        // plane y <= 2: negative normal takes the low corner
        drive_word(plane_word(3'd1, '0, -Q_ONE, '0, 2 * Q_ONE));
        drive_word(box_word(MODE_ALL, 3'd0, '0, 3 * Q_ONE, '0, Q_ONE, 5 * Q_ONE, '0));
        drive_word(box_word(MODE_ALL, 3'd0, '0, Q_ONE, '0, Q_ONE, 5 * Q_ONE, '0));
        // swapped corners are taken as given
        drive_word(box_word(MODE_ONE, 3'd1, '0, 5 * Q_ONE, '0, '0, Q_ONE, '0));
        drive_word(box_word(MODE_NONE, 3'd7, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom));
        // extreme planes, beyond the plane count
        drive_word(plane_word(3'd7, V_MIN, V_MIN, V_MIN, V_MAX));
        drive_word(box_word(MODE_ONE, 3'd7, V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
        drive_word(box_word(MODE_ONE, 3'd7, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX));
        drive_word(plane_word(3'd6, V_MAX, V_MAX, V_MAX, V_MIN));
        drive_word(box_word(MODE_ONE, 3'd6, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN));
        drive_word(box_word(MODE_ONE, 3'd6, V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
        drive_word(box_word(MODE_ALL, 3'd0, '0, '0, '0, '0, '0, '0));
        // count zero tests nothing; above the table clamps to all planes
        set_plane_count(4'd0);
        drive_word(box_word(MODE_ALL, 3'd0, -5 * Q_ONE, '0, '0, -Q_ONE, '0, '0));
        set_plane_count(4'd15);
        drive_word(box_word(MODE_ALL, 3'd0, '0, '0, '0, '0, '0, '0));
        drive_word(box_word(MODE_ALL, 3'd0, V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
        set_plane_count(4'd7);
        drive_word(box_word(MODE_ALL, 3'd0, '0, '0, '0, '0, '0, '0));

        for (int ph = 0; ph < 11; ph++) begin
            set_plane_count(phase_counts[ph]);
            no_idle = (ph == 4 || ph == 8);
            roomy   = ph[0];
            if (ph == 2)
                hold_req = 1'b1;  // block fills up while the sender keeps going
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                drive_word(random_word());
        end

        drain();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
